// ===== src/aat_pkg.sv =====
// Shared widths, Q16 angle constants and the arctangent table for the
// accelerometer averaging and tilt-angle block. No dependencies.
`timescale 1ns / 1ps

package aat_pkg;

    // default number of cordic iterations
    localparam int AAT_CORDIC_STEPS = 16;

    // field widths
    localparam int SAMPLE_W  = 16;
    localparam int AVG_W     = 13;
    localparam int ROLL_W    = 9;
    localparam int PITCH_W   = 8;
    localparam int TILT_W    = 8;

    // configuration port
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TICKS_PER_SAMPLE    = 1'b0,
        CFG_SAMPLES_PER_AVERAGE = 1'b1
    } cfg_index_t;

    // register reset values
    localparam logic [CFG_W-1:0] TICKS_PER_SAMPLE_RST    = 8'd2;
    localparam logic [CFG_W-1:0] SAMPLES_PER_AVERAGE_RST = 8'd20;

    // averaging divisor is samples times this scale
    localparam int AVG_SCALE  = 10;

    // internal widths
    localparam int SUM_W      = 24;
    localparam int DIVISOR_W  = 12;
    localparam int QUO_W      = 12;
    localparam int DIV_STEPS  = QUO_W;
    localparam int SQ_W       = 25;
    localparam int ROOT_W     = 29;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int REM_W      = 32;
    localparam int Q_FRAC     = 16;
    localparam int CO_W       = 32;
    localparam int ACC_W      = 26;
    localparam int ATAN_W     = 22;
    localparam int ATAN_IDX_W = 5;
    localparam int DEG_W      = 11;

    // angle constants in q16 degrees
    localparam logic signed [ACC_W-1:0] ACC_180 = 26'sd11796480;
    localparam logic signed [ACC_W-1:0] ACC_90  = 26'sd5898240;

    // clamp limits in whole degrees
    localparam logic signed [DEG_W-1:0] ROLL_MIN  = -11'sd180;
    localparam logic signed [DEG_W-1:0] ROLL_MAX  = 11'sd180;
    localparam logic signed [DEG_W-1:0] PITCH_MIN = -11'sd90;
    localparam logic signed [DEG_W-1:0] PITCH_MAX = 11'sd90;
    localparam logic signed [DEG_W-1:0] TILT_MIN  = 11'sd0;
    localparam logic signed [DEG_W-1:0] TILT_MAX  = 11'sd180;

    // atan(2^-i) in q16 degrees
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 22'd2949120;
            5'd1:    v = 22'd1740967;
            5'd2:    v = 22'd919879;
            5'd3:    v = 22'd466945;
            5'd4:    v = 22'd234379;
            5'd5:    v = 22'd117304;
            5'd6:    v = 22'd58666;
            5'd7:    v = 22'd29335;
            5'd8:    v = 22'd14668;
            5'd9:    v = 22'd7334;
            5'd10:   v = 22'd3667;
            5'd11:   v = 22'd1833;
            5'd12:   v = 22'd917;
            5'd13:   v = 22'd458;
            5'd14:   v = 22'd229;
            5'd15:   v = 22'd115;
            5'd16:   v = 22'd57;
            5'd17:   v = 22'd29;
            5'd18:   v = 22'd14;
            5'd19:   v = 22'd7;
            5'd20:   v = 22'd4;
            5'd21:   v = 22'd2;
            5'd22:   v = 22'd1;
            default: v = 22'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/aat_sample_if.sv =====
// Valid/ready channel carrying one three-axis accelerometer tick.
// Depends on aat_pkg for the field widths.
`timescale 1ns / 1ps

interface aat_sample_if import aat_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic signed [SAMPLE_W-1:0] z_sample;

    modport source (output valid, output x_sample, output y_sample, output z_sample,
                    input ready);
    modport sink   (input valid, input x_sample, input y_sample, input z_sample,
                    output ready);

endinterface

// ===== src/aat_result_if.sv =====
// Valid/ready channel carrying one averaged result with its tilt angles.
// Depends on aat_pkg for the field widths.
`timescale 1ns / 1ps

interface aat_result_if import aat_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [AVG_W-1:0]   avg_x;
    logic signed [AVG_W-1:0]   avg_y;
    logic signed [AVG_W-1:0]   avg_z;
    logic signed [ROLL_W-1:0]  roll_deg;
    logic signed [PITCH_W-1:0] pitch_deg;
    logic        [TILT_W-1:0]  tilt_deg;
    logic                      any_nonzero;

    modport source (output valid, output avg_x, output avg_y, output avg_z,
                    output roll_deg, output pitch_deg, output tilt_deg,
                    output any_nonzero, input ready);
    modport sink   (input valid, input avg_x, input avg_y, input avg_z,
                    input roll_deg, input pitch_deg, input tilt_deg,
                    input any_nonzero, output ready);

endinterface

// ===== src/accel_average_tilt_angles.sv =====
// Top level of the accelerometer averaging and tilt-angle block.
// Depends on aat_pkg, aat_sample_if and aat_result_if.
`timescale 1ns / 1ps

// Every tick transfer is counted; each ticks_per_sample-th tick adds its three axes to
// 24-bit sums, and after samples_per_average such samples the block computes the three
// averages (sum / (samples * 10), truncated toward zero) and roll, pitch and tilt in
// whole degrees. A tick that completes no average leaves the block ready for the next.
// A completing tick keeps the block busy through a one-bit-per-cycle restoring divide
// for each axis, two bit-pair-per-cycle integer square roots (both divide and root
// through one shared 32-bit subtractor) and three vectoring CORDIC passes of CORDIC_STEPS
// iterations, all under one sequencer. An angle whose vector lies on an axis skips its
// iterations. Ticks that complete no average are still taken while a finished result
// waits on the output register.

module accel_average_tilt_angles import aat_pkg::*; #(
    parameter int CORDIC_STEPS = AAT_CORDIC_STEPS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    aat_sample_if.sink           samples,
    aat_result_if.source         results
);

    localparam int LOOP_MAX = (SQRT_STEPS > CORDIC_STEPS) ? SQRT_STEPS : CORDIC_STEPS;
    localparam int CNT_W    = $clog2(LOOP_MAX);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);
    localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] CO_LAST  = CNT_W'(CORDIC_STEPS - 1);
    localparam int EXT_AVG  = CO_W - AVG_W - Q_FRAC;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_SQ_MUL0,
        S_SQ_MUL1,
        S_SQ_STEP,
        S_CO_LOAD,
        S_CO_STEP,
        S_CO_DONE,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        ANG_ROLL,
        ANG_PITCH,
        ANG_TILT
    } angle_t;

    // configuration and counting state
    logic [CFG_W-1:0]  tps_reg;
    logic [CFG_W-1:0]  spa_reg;
    logic [7:0]        tick_count_reg;
    logic [7:0]        sample_count_reg;
    logic [SUM_W-1:0]  axis_sums_reg [3];

    // sequencer
    state_t            state_reg;
    angle_t            angle_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [1:0]        axis_reg;

    // divider
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [QUO_W-1:0]     div_rem_reg;
    logic [QUO_W-1:0]     div_low_reg;
    logic [QUO_W-1:0]     div_quo_reg;
    logic                 div_neg_reg;
    logic signed [AVG_W-1:0] avg_reg [3];

    // square root
    logic [SQ_W-1:0]   sq_acc_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  sq_rem_reg;
    logic [ROOT_W-1:0] sq_root_reg;
    logic [ROOT_W-1:0] mag_reg;

    // cordic
    logic signed [CO_W-1:0]  co_x_reg;
    logic signed [CO_W-1:0]  co_y_reg;
    logic signed [ACC_W-1:0] co_acc_reg;
    logic signed [ROLL_W-1:0]  roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic        [TILT_W-1:0]  tilt_reg;

    // output register
    logic                      out_valid_reg;
    logic signed [AVG_W-1:0]   out_avg_x_reg;
    logic signed [AVG_W-1:0]   out_avg_y_reg;
    logic signed [AVG_W-1:0]   out_avg_z_reg;
    logic signed [ROLL_W-1:0]  out_roll_reg;
    logic signed [PITCH_W-1:0] out_pitch_reg;
    logic        [TILT_W-1:0]  out_tilt_reg;
    logic                      out_nonzero_reg;

    // tick and sample counting
    logic [CFG_W-1:0]    tps_eff;
    logic [CFG_W-1:0]    spa_eff;
    logic [7:0]          tick_inc;
    logic [7:0]          samp_inc;
    logic                tick_hit;
    logic                samp_hit;
    logic                in_xfer;
    logic [SAMPLE_W-1:0] sample_vec [3];
    logic [SUM_W-1:0]    sum_add [3];

    assign tps_eff  = (tps_reg == '0) ? CFG_W'(1) : tps_reg;
    assign spa_eff  = (spa_reg == '0) ? CFG_W'(1) : spa_reg;
    assign tick_inc = tick_count_reg + 8'd1;
    assign samp_inc = sample_count_reg + 8'd1;
    assign tick_hit = (tick_inc >= tps_eff);
    assign samp_hit = (samp_inc >= spa_eff);
    assign in_xfer  = samples.valid && samples.ready;

    assign sample_vec[0] = samples.x_sample;
    assign sample_vec[1] = samples.y_sample;
    assign sample_vec[2] = samples.z_sample;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sum_add[k] = axis_sums_reg[k]
                       + {{(SUM_W-SAMPLE_W){sample_vec[k][SAMPLE_W-1]}}, sample_vec[k]};
        end
    end

    // shared subtractor for divide and root trials
    logic [REM_W-1:0] sub_a;
    logic [REM_W-1:0] sub_b;
    logic [REM_W:0]   sub_diff;
    logic             sub_borrow;

    // divider step
    logic [SUM_W-1:0]     div_src;
    logic [SUM_W-1:0]     div_abs;
    logic [QUO_W:0]       div_rem_sh;
    logic [QUO_W-1:0]     div_quo_next;
    logic [AVG_W-1:0]     div_quo_ext;
    logic signed [AVG_W-1:0] div_avg;

    assign div_src      = axis_sums_reg[axis_reg];
    assign div_abs      = div_src[SUM_W-1] ? (~div_src + SUM_W'(1)) : div_src;
    assign div_rem_sh   = {div_rem_reg, div_low_reg[QUO_W-1]};
    assign div_quo_next = {div_quo_reg[QUO_W-2:0], ~sub_borrow};
    assign div_quo_ext  = {1'b0, div_quo_next};
    assign div_avg      = div_neg_reg ? $signed(~div_quo_ext + AVG_W'(1))
                                      : $signed(div_quo_ext);

    // root step
    logic [REM_W-1:0]  sq_rem_sh;
    logic [REM_W-1:0]  sq_trial;
    logic [ROOT_W-1:0] sq_root_next;

    assign sq_rem_sh    = {sq_rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign sq_trial     = {1'b0, sq_root_reg, 2'b01};
    assign sq_root_next = {sq_root_reg[ROOT_W-2:0], ~sub_borrow};

    always_comb
    begin
        if (state_reg == S_DIV_STEP)
        begin
            sub_a = REM_W'(div_rem_sh);
            sub_b = REM_W'(divisor_reg);
        end
        else
        begin
            sub_a = sq_rem_sh;
            sub_b = sq_trial;
        end
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[REM_W];

    // squaring for the magnitudes, one product a cycle
    logic signed [AVG_W-1:0]   mul_op;
    logic signed [2*AVG_W-1:0] mul_prod;
    logic [SQ_W-1:0]           mul_sq;
    logic [SQ_W-1:0]           sq_sum;

    always_comb
    begin
        if (angle_reg == ANG_PITCH)
            mul_op = (state_reg == S_SQ_MUL0) ? avg_reg[1] : avg_reg[2];
        else
            mul_op = (state_reg == S_SQ_MUL0) ? avg_reg[0] : avg_reg[1];
    end

    assign mul_prod = mul_op * mul_op;
    assign mul_sq   = mul_prod[SQ_W-1:0];
    assign sq_sum   = sq_acc_reg + mul_sq;

    // cordic operands in q16
    logic signed [CO_W-1:0] q_avg_x;
    logic signed [CO_W-1:0] q_avg_y;
    logic signed [CO_W-1:0] q_avg_z;
    logic signed [CO_W-1:0] q_mag;
    logic signed [CO_W-1:0] ld_x;
    logic signed [CO_W-1:0] ld_y;

    assign q_avg_x = {{EXT_AVG{avg_reg[0][AVG_W-1]}}, avg_reg[0], {Q_FRAC{1'b0}}};
    assign q_avg_y = {{EXT_AVG{avg_reg[1][AVG_W-1]}}, avg_reg[1], {Q_FRAC{1'b0}}};
    assign q_avg_z = {{EXT_AVG{avg_reg[2][AVG_W-1]}}, avg_reg[2], {Q_FRAC{1'b0}}};
    assign q_mag   = {{(CO_W-ROOT_W){1'b0}}, mag_reg};

    always_comb
    begin
        case (angle_reg)
            ANG_ROLL:
            begin
                ld_y = q_avg_y;
                ld_x = q_avg_z;
            end
            ANG_PITCH:
            begin
                ld_y = -q_avg_x;
                ld_x = q_mag;
            end
            ANG_TILT:
            begin
                ld_y = q_mag;
                ld_x = q_avg_z;
            end
            default:
            begin
                ld_y = '0;
                ld_x = '0;
            end
        endcase
    end

    // cordic iteration
    logic                    co_y_pos;
    logic signed [CO_W-1:0]  co_xs;
    logic signed [CO_W-1:0]  co_ys;
    logic signed [ACC_W-1:0] co_atan;

    assign co_y_pos = !co_y_reg[CO_W-1] && (co_y_reg != '0);
    assign co_xs    = co_x_reg >>> cnt_reg;
    assign co_ys    = co_y_reg >>> cnt_reg;
    assign co_atan  = $signed({{(ACC_W-ATAN_W){1'b0}}, atan_q16(ATAN_IDX_W'(cnt_reg))});

    // q16 angle to clamped whole degrees
    logic [ACC_W-1:0]        acc_abs;
    logic [DEG_W-1:0]        deg_abs;
    logic signed [DEG_W-1:0] deg_val;
    logic signed [DEG_W-1:0] deg_lo;
    logic signed [DEG_W-1:0] deg_hi;
    logic signed [DEG_W-1:0] deg_clamped;

    assign acc_abs = co_acc_reg[ACC_W-1] ? (~co_acc_reg + ACC_W'(1)) : co_acc_reg;
    assign deg_abs = {1'b0, acc_abs[ACC_W-1:Q_FRAC]};
    assign deg_val = co_acc_reg[ACC_W-1] ? $signed(~deg_abs + DEG_W'(1)) : $signed(deg_abs);

    always_comb
    begin
        case (angle_reg)
            ANG_ROLL:
            begin
                deg_lo = ROLL_MIN;
                deg_hi = ROLL_MAX;
            end
            ANG_PITCH:
            begin
                deg_lo = PITCH_MIN;
                deg_hi = PITCH_MAX;
            end
            ANG_TILT:
            begin
                deg_lo = TILT_MIN;
                deg_hi = TILT_MAX;
            end
            default:
            begin
                deg_lo = '0;
                deg_hi = '0;
            end
        endcase
        if (deg_val < deg_lo)
            deg_clamped = deg_lo;
        else if (deg_val > deg_hi)
            deg_clamped = deg_hi;
        else
            deg_clamped = deg_val;
    end

    // sequencer, datapath and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg          <= TICKS_PER_SAMPLE_RST;
            spa_reg          <= SAMPLES_PER_AVERAGE_RST;
            tick_count_reg   <= '0;
            sample_count_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                axis_sums_reg[k] <= '0;
                avg_reg[k]       <= '0;
            end
            state_reg        <= S_IDLE;
            angle_reg        <= ANG_ROLL;
            cnt_reg          <= '0;
            axis_reg         <= '0;
            divisor_reg      <= '0;
            div_rem_reg      <= '0;
            div_low_reg      <= '0;
            div_quo_reg      <= '0;
            div_neg_reg      <= 1'b0;
            sq_acc_reg       <= '0;
            rad_reg          <= '0;
            sq_rem_reg       <= '0;
            sq_root_reg      <= '0;
            mag_reg          <= '0;
            co_x_reg         <= '0;
            co_y_reg         <= '0;
            co_acc_reg       <= '0;
            roll_reg         <= '0;
            pitch_reg        <= '0;
            tilt_reg         <= '0;
            out_valid_reg    <= 1'b0;
            out_avg_x_reg    <= '0;
            out_avg_y_reg    <= '0;
            out_avg_z_reg    <= '0;
            out_roll_reg     <= '0;
            out_pitch_reg    <= '0;
            out_tilt_reg     <= '0;
            out_nonzero_reg  <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TICKS_PER_SAMPLE:    tps_reg <= cfg_data;
                    CFG_SAMPLES_PER_AVERAGE: spa_reg <= cfg_data;
                    default:                 ;
                endcase
            end

            // result transfer frees the output register unless a reading is loaded
            if (results.ready && (state_reg != S_OUT))
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        if (!tick_hit)
                            tick_count_reg <= tick_inc;
                        else
                        begin
                            tick_count_reg <= '0;
                            for (int k = 0; k < 3; k++)
                                axis_sums_reg[k] <= sum_add[k];
                            if (!samp_hit)
                                sample_count_reg <= samp_inc;
                            else
                            begin
                                sample_count_reg <= '0;
                                divisor_reg <= DIVISOR_W'(samp_inc) * DIVISOR_W'(AVG_SCALE);
                                axis_reg    <= '0;
                                state_reg   <= S_DIV_LOAD;
                            end
                        end
                    end
                end

                S_DIV_LOAD:
                begin
                    div_neg_reg             <= div_src[SUM_W-1];
                    div_rem_reg             <= div_abs[SUM_W-1:QUO_W];
                    div_low_reg             <= div_abs[QUO_W-1:0];
                    div_quo_reg             <= '0;
                    axis_sums_reg[axis_reg] <= '0;
                    cnt_reg                 <= '0;
                    state_reg               <= S_DIV_STEP;
                end

                S_DIV_STEP:
                begin
                    div_rem_reg <= sub_borrow ? div_rem_sh[QUO_W-1:0] : sub_diff[QUO_W-1:0];
                    div_low_reg <= {div_low_reg[QUO_W-2:0], 1'b0};
                    div_quo_reg <= div_quo_next;
                    cnt_reg     <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == DIV_LAST)
                    begin
                        avg_reg[axis_reg] <= div_avg;
                        if (axis_reg == 2'd2)
                        begin
                            angle_reg <= ANG_ROLL;
                            state_reg <= S_CO_LOAD;
                        end
                        else
                        begin
                            axis_reg  <= axis_reg + 2'd1;
                            state_reg <= S_DIV_LOAD;
                        end
                    end
                end

                S_SQ_MUL0:
                begin
                    sq_acc_reg <= mul_sq;
                    state_reg  <= S_SQ_MUL1;
                end

                S_SQ_MUL1:
                begin
                    rad_reg     <= {{(RAD_W-SQ_W-2*Q_FRAC){1'b0}}, sq_sum, {(2*Q_FRAC){1'b0}}};
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    cnt_reg     <= '0;
                    state_reg   <= S_SQ_STEP;
                end

                S_SQ_STEP:
                begin
                    sq_rem_reg  <= sub_borrow ? sq_rem_sh : sub_diff[REM_W-1:0];
                    sq_root_reg <= sq_root_next;
                    rad_reg     <= {rad_reg[RAD_W-3:0], 2'b00};
                    cnt_reg     <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == SQ_LAST)
                    begin
                        mag_reg   <= sq_root_next;
                        state_reg <= S_CO_LOAD;
                    end
                end

                S_CO_LOAD:
                begin
                    cnt_reg <= '0;
                    if (ld_y == '0)
                    begin
                        // on the x axis: zero or a half turn
                        co_acc_reg <= ld_x[CO_W-1] ? ACC_180 : '0;
                        state_reg  <= S_CO_DONE;
                    end
                    else if (ld_x == '0)
                    begin
                        // on the y axis: exact quarter turn
                        co_acc_reg <= ld_y[CO_W-1] ? -ACC_90 : ACC_90;
                        state_reg  <= S_CO_DONE;
                    end
                    else if (ld_x[CO_W-1])
                    begin
                        // left half plane: turn by a half turn first
                        co_acc_reg <= ld_y[CO_W-1] ? -ACC_180 : ACC_180;
                        co_x_reg   <= -ld_x;
                        co_y_reg   <= -ld_y;
                        state_reg  <= S_CO_STEP;
                    end
                    else
                    begin
                        co_acc_reg <= '0;
                        co_x_reg   <= ld_x;
                        co_y_reg   <= ld_y;
                        state_reg  <= S_CO_STEP;
                    end
                end

                S_CO_STEP:
                begin
                    if (co_y_pos)
                    begin
                        co_x_reg   <= co_x_reg + co_ys;
                        co_y_reg   <= co_y_reg - co_xs;
                        co_acc_reg <= co_acc_reg + co_atan;
                    end
                    else
                    begin
                        co_x_reg   <= co_x_reg - co_ys;
                        co_y_reg   <= co_y_reg + co_xs;
                        co_acc_reg <= co_acc_reg - co_atan;
                    end
                    cnt_reg <= cnt_reg + CNT_W'(1);
                    if (cnt_reg == CO_LAST)
                        state_reg <= S_CO_DONE;
                end

                S_CO_DONE:
                begin
                    case (angle_reg)
                        ANG_ROLL:
                        begin
                            roll_reg  <= ROLL_W'(deg_clamped);
                            angle_reg <= ANG_PITCH;
                            state_reg <= S_SQ_MUL0;
                        end
                        ANG_PITCH:
                        begin
                            pitch_reg <= PITCH_W'(deg_clamped);
                            angle_reg <= ANG_TILT;
                            state_reg <= S_SQ_MUL0;
                        end
                        default:
                        begin
                            tilt_reg  <= TILT_W'(deg_clamped);
                            state_reg <= S_OUT;
                        end
                    endcase
                end

                S_OUT:
                begin
                    // move the finished reading into a free output register
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_avg_x_reg   <= avg_reg[0];
                        out_avg_y_reg   <= avg_reg[1];
                        out_avg_z_reg   <= avg_reg[2];
                        out_roll_reg    <= roll_reg;
                        out_pitch_reg   <= pitch_reg;
                        out_tilt_reg    <= tilt_reg;
                        out_nonzero_reg <= (avg_reg[0] != '0) || (avg_reg[1] != '0)
                                        || (avg_reg[2] != '0);
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // channel outputs
    assign samples.ready       = (state_reg == S_IDLE);
    assign results.valid       = out_valid_reg;
    assign results.avg_x       = out_avg_x_reg;
    assign results.avg_y       = out_avg_y_reg;
    assign results.avg_z       = out_avg_z_reg;
    assign results.roll_deg    = out_roll_reg;
    assign results.pitch_deg   = out_pitch_reg;
    assign results.tilt_deg    = out_tilt_reg;
    assign results.any_nonzero = out_nonzero_reg;

endmodule

// ===== tb/aat_reading_checker.sv =====
// Checker for the accelerometer averaging and tilt-angle block: watches the tick,
// result and register-write ports, predicts every averaged reading and compares it.
// Depends on aat_pkg, aat_sample_if and aat_result_if.
`timescale 1ns / 1ps

module aat_reading_checker import aat_pkg::*; #(
    parameter int CORDIC_STEPS = AAT_CORDIC_STEPS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    aat_sample_if                samples,
    aat_result_if                results,
    output int                   failures,
    output int                   pending
);

    localparam longint DEG_ONE = 65536;
    localparam int     MAX_PRINTED = 40;

    typedef struct packed {
        logic signed [AVG_W-1:0]   avg_x;
        logic signed [AVG_W-1:0]   avg_y;
        logic signed [AVG_W-1:0]   avg_z;
        logic signed [ROLL_W-1:0]  roll_deg;
        logic signed [PITCH_W-1:0] pitch_deg;
        logic        [TILT_W-1:0]  tilt_deg;
        logic                      any_nonzero;
    } reading_t;

    // atan(2^-i) in q16 degrees, rounded
    longint atan_step_q16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    logic [CFG_W-1:0]        ticks_cfg;
    logic [CFG_W-1:0]        samples_cfg;
    logic [7:0]              tick_cnt;
    logic [7:0]              sample_cnt;
    logic signed [SUM_W-1:0] axis_total [3];
    reading_t                expected_readings [$];

    // floor square root, bit-pair method
    function automatic longint unsigned root_floor(input longint unsigned n_in);
        longint unsigned n;
        longint unsigned r;
        longint unsigned probe;
        n = n_in;
        r = 0;
        probe = 64'h4000_0000_0000_0000;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (n >= r + probe)
            begin
                n = n - (r + probe);
                r = (r >> 1) + probe;
            end
            else
            begin
                r = r >> 1;
            end
            probe = probe >> 2;
        end
        return r;
    endfunction

    // atan2(yy, xx) in q16 degrees by vectoring cordic
    function automatic longint vector_angle(input longint yy_in, input longint xx_in);
        longint yy;
        longint xx;
        longint acc;
        longint nx;
        longint ny;
        int     i;
        yy = yy_in;
        xx = xx_in;
        acc = 0;
        if (yy == 0)
            return (xx < 0) ? 180 * DEG_ONE : 0;
        if (xx == 0)
            return (yy > 0) ? 90 * DEG_ONE : -90 * DEG_ONE;
        // left half plane: turn by a half circle first
        if (xx < 0)
        begin
            acc = (yy > 0) ? 180 * DEG_ONE : -180 * DEG_ONE;
            xx = -xx;
            yy = -yy;
        end
        for (i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            if (yy > 0)
            begin
                nx = xx + (yy >>> i);
                ny = yy - (xx >>> i);
                acc = acc + atan_step_q16[i];
            end
            else
            begin
                nx = xx - (yy >>> i);
                ny = yy + (xx >>> i);
                acc = acc - atan_step_q16[i];
            end
            xx = nx;
            yy = ny;
        end
        return acc;
    endfunction

    // q16 degrees to whole degrees toward zero, then clamped
    function automatic longint whole_degrees(input longint q, input longint lo,
                                             input longint hi);
        longint d;
        d = q / DEG_ONE;
        if (d < lo)
            d = lo;
        if (d > hi)
            d = hi;
        return d;
    endfunction

    // averages and angles from the axis totals over n samples
    function automatic reading_t reading_from_totals(input longint sx, input longint sy,
                                                     input longint sz, input longint n);
        reading_t r;
        longint   divisor;
        longint   ax;
        longint   ay;
        longint   az;
        longint   mag_yz;
        longint   mag_xy;
        longint   roll;
        longint   pitch;
        longint   tilt;
        divisor = n * AVG_SCALE;
        ax = sx / divisor;
        ay = sy / divisor;
        az = sz / divisor;
        mag_yz = longint'(root_floor(longint'(ay * ay + az * az) << 32));
        mag_xy = longint'(root_floor(longint'(ax * ax + ay * ay) << 32));
        roll  = whole_degrees(vector_angle(ay * DEG_ONE, az * DEG_ONE), -180, 180);
        pitch = whole_degrees(vector_angle(-ax * DEG_ONE, mag_yz), -90, 90);
        tilt  = whole_degrees(vector_angle(mag_xy, az * DEG_ONE), 0, 180);
        r.avg_x = AVG_W'(ax);
        r.avg_y = AVG_W'(ay);
        r.avg_z = AVG_W'(az);
        r.roll_deg = ROLL_W'(roll);
        r.pitch_deg = PITCH_W'(pitch);
        r.tilt_deg = TILT_W'(tilt);
        r.any_nonzero = (ax != 0) || (ay != 0) || (az != 0);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (failures < MAX_PRINTED)
            $display("%0t: %s", $time, msg);
        failures = failures + 1;
    endtask

    // decimate, accumulate and emit a reading when the window closes
    task automatic take_tick(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y,
                             input logic signed [SAMPLE_W-1:0] z);
        int tps_eff;
        int spa_eff;
        tps_eff = (ticks_cfg == 0) ? 1 : int'(ticks_cfg);
        spa_eff = (samples_cfg == 0) ? 1 : int'(samples_cfg);
        tick_cnt = tick_cnt + 8'd1;
        if (int'(tick_cnt) >= tps_eff)
        begin
            tick_cnt = 8'd0;
            axis_total[0] = axis_total[0] + x;
            axis_total[1] = axis_total[1] + y;
            axis_total[2] = axis_total[2] + z;
            sample_cnt = sample_cnt + 8'd1;
            if (int'(sample_cnt) >= spa_eff)
            begin
                expected_readings.push_back(reading_from_totals(axis_total[0],
                    axis_total[1], axis_total[2], longint'(sample_cnt)));
                axis_total[0] = '0;
                axis_total[1] = '0;
                axis_total[2] = '0;
                sample_cnt = 8'd0;
            end
        end
    endtask

    // watch all ports; results are checked before the tick of the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        reading_t want;
        if (!rst_n)
        begin
            ticks_cfg = TICKS_PER_SAMPLE_RST;
            samples_cfg = SAMPLES_PER_AVERAGE_RST;
            tick_cnt = 8'd0;
            sample_cnt = 8'd0;
            axis_total[0] = '0;
            axis_total[1] = '0;
            axis_total[2] = '0;
            expected_readings.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TICKS_PER_SAMPLE:    ticks_cfg = cfg_data;
                    CFG_SAMPLES_PER_AVERAGE: samples_cfg = cfg_data;
                    default: ;
                endcase
            end

            if (results.valid && results.ready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch("result transfer with no reading expected");
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (results.avg_x !== want.avg_x)
                        report_mismatch($sformatf("avg_x got %0d expected %0d",
                                                  results.avg_x, want.avg_x));
                    if (results.avg_y !== want.avg_y)
                        report_mismatch($sformatf("avg_y got %0d expected %0d",
                                                  results.avg_y, want.avg_y));
                    if (results.avg_z !== want.avg_z)
                        report_mismatch($sformatf("avg_z got %0d expected %0d",
                                                  results.avg_z, want.avg_z));
                    if (results.roll_deg !== want.roll_deg)
                        report_mismatch($sformatf("roll_deg got %0d expected %0d",
                                                  results.roll_deg, want.roll_deg));
                    if (results.pitch_deg !== want.pitch_deg)
                        report_mismatch($sformatf("pitch_deg got %0d expected %0d",
                                                  results.pitch_deg, want.pitch_deg));
                    if (results.tilt_deg !== want.tilt_deg)
                        report_mismatch($sformatf("tilt_deg got %0d expected %0d",
                                                  results.tilt_deg, want.tilt_deg));
                    if (results.any_nonzero !== want.any_nonzero)
                        report_mismatch($sformatf("any_nonzero got %0d expected %0d",
                                                  results.any_nonzero, want.any_nonzero));
                end
            end

            if (samples.valid && samples.ready)
                take_tick(samples.x_sample, samples.y_sample, samples.z_sample);

            pending <= expected_readings.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the testbench for accel_average_tilt_angles: clock, reset, register writes,
// tick stimulus with bursts and gaps, result back-pressure and the final verdict.
// Depends on aat_pkg, the two channel interfaces, the block and aat_reading_checker.
`timescale 1ns / 1ps

module tb import aat_pkg::*; ();

    localparam int STEPS         = AAT_CORDIC_STEPS;
    localparam int SETTLE_CYCLES = 220;
    localparam int LONG_HOLD     = 1500;
    // ticks sent by the random phases, on top of the directed ones
    localparam int TICK_TARGET   = 120;

    localparam logic signed [SAMPLE_W-1:0] AXIS_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] AXIS_MIN = 16'sh8000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 hold_req;
    int                   failures;
    int                   pending;

    aat_sample_if samples ();
    aat_result_if results ();

    accel_average_tilt_angles #(
        .CORDIC_STEPS(STEPS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .samples  (samples),
        .results  (results)
    );

    aat_reading_checker #(
        .CORDIC_STEPS(STEPS)
    ) reading_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .samples  (samples),
        .results  (results),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // one tick transfer
    task automatic send_tick(input logic signed [SAMPLE_W-1:0] x,
                             input logic signed [SAMPLE_W-1:0] y,
                             input logic signed [SAMPLE_W-1:0] z);
        samples.valid <= 1'b1;
        samples.x_sample <= x;
        samples.y_sample <= y;
        samples.z_sample <= z;
        do
            @(posedge clk);
        while (!samples.ready);
    endtask

    task automatic pause_sender(input int cycles);
        samples.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop sending and let every expected reading come out
    task automatic settle();
        samples.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // axis value weighted toward the extremes, zero and small magnitudes
    function automatic int axis_value();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            2:       return 0;
            3, 4:    return int'($urandom_range(0, 200)) - 100;
            5, 6:    return int'($urandom_range(0, 8000)) - 4000;
            default: return int'($urandom_range(0, 65535)) - 32768;
        endcase
    endfunction

    // centre plus noise, saturated to the sample range
    function automatic logic signed [SAMPLE_W-1:0] near(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return SAMPLE_W'(v);
    endfunction

    // one setting of both registers and nsamp samples worth of ticks
    task automatic run_phase(input int tps, input int spa, input int nsamp,
                             input bit gaps, input bit steady);
        int ticks;
        int burst_left;
        int bx;
        int by;
        int bz;
        int spread;
        int k;
        write_reg(CFG_TICKS_PER_SAMPLE, CFG_W'(tps));
        write_reg(CFG_SAMPLES_PER_AVERAGE, CFG_W'(spa));
        ticks = nsamp * ((tps == 0) ? 1 : tps);
        burst_left = $urandom_range(1, 16);
        // a steady orientation with noise gives coherent averages
        bx = axis_value();
        by = axis_value();
        bz = axis_value();
        spread = $urandom_range(0, 64);
        for (k = 0; k < ticks; k++)
        begin
            if (steady)
                send_tick(near(bx, spread), near(by, spread), near(bz, spread));
            else
                send_tick(near(axis_value(), 0), near(axis_value(), 0),
                          near(axis_value(), 0));
            if (gaps)
            begin
                burst_left--;
                if (burst_left == 0)
                begin
                    pause_sender($urandom_range(1, 8));
                    burst_left = $urandom_range(1, 16);
                end
            end
        end
        settle();
    endtask

    // result side: stall pattern of its own plus one long hold-off on request
    initial
    begin : receiver
        int  left;
        int  mode;
        bit  served;
        results.ready = 1'b0;
        left = 0;
        mode = 0;
        served = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !served)
            begin
                served = 1'b1;
                results.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(1, 40);
                end
                left--;
                case (mode)
                    0, 1:    results.ready <= 1'b1;
                    2:       results.ready <= 1'($urandom_range(0, 1));
                    default: results.ready <= 1'b0;
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int taken;
        int tps;
        int spa;
        int nsamp;
        int r;
        samples.valid = 1'b0;
        samples.x_sample = '0;
        samples.y_sample = '0;
        samples.z_sample = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_TICKS_PER_SAMPLE;
        cfg_data = '0;
        hold_req = 1'b0;
        rst_n = 1'b0;
        taken = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // one reading per tick: extremes, axis-aligned vectors, truncation
        write_reg(CFG_TICKS_PER_SAMPLE, 8'd1);
        write_reg(CFG_SAMPLES_PER_AVERAGE, 8'd1);
        send_tick(16'sd0, 16'sd0, 16'sd0);
        send_tick(AXIS_MAX, AXIS_MAX, AXIS_MAX);
        send_tick(AXIS_MIN, AXIS_MIN, AXIS_MIN);
        send_tick(16'sd0, 16'sd0, AXIS_MAX);
        send_tick(16'sd0, 16'sd0, AXIS_MIN);
        send_tick(16'sd0, AXIS_MAX, 16'sd0);
        send_tick(16'sd0, AXIS_MIN, 16'sd0);
        send_tick(AXIS_MAX, 16'sd0, 16'sd0);
        send_tick(AXIS_MIN, 16'sd0, 16'sd0);
        send_tick(16'sd5, 16'sd5, 16'sd5);
        send_tick(-16'sd9, 16'sd10, -16'sd10);
        send_tick(16'sd100, -16'sd200, -16'sd300);
        send_tick(-16'sd300, 16'sd200, -16'sd100);
        settle();

        // zero in both registers behaves as one
        write_reg(CFG_TICKS_PER_SAMPLE, 8'd0);
        write_reg(CFG_SAMPLES_PER_AVERAGE, 8'd0);
        send_tick(16'sd1234, -16'sd5678, 16'sd910);
        send_tick(AXIS_MIN, AXIS_MAX, 16'sd0);
        settle();

        // decimation by three, two samples per reading
        write_reg(CFG_TICKS_PER_SAMPLE, 8'd3);
        write_reg(CFG_SAMPLES_PER_AVERAGE, 8'd2);
        send_tick(16'sd700, 16'sd800, 16'sd900);
        send_tick(16'sd1, 16'sd2, 16'sd3);
        send_tick(-16'sd700, 16'sd150, 16'sd2000);
        send_tick(16'sd4, 16'sd5, 16'sd6);
        send_tick(16'sd7, 16'sd8, 16'sd9);
        send_tick(-16'sd50, -16'sd600, 16'sd1000);
        settle();

        // sample limit lowered below a partial count
        write_reg(CFG_TICKS_PER_SAMPLE, 8'd1);
        write_reg(CFG_SAMPLES_PER_AVERAGE, 8'd5);
        send_tick(16'sd400, -16'sd400, 16'sd4000);
        send_tick(16'sd410, -16'sd390, 16'sd4010);
        send_tick(16'sd390, -16'sd410, 16'sd3990);
        settle();
        write_reg(CFG_SAMPLES_PER_AVERAGE, 8'd2);
        send_tick(16'sd400, -16'sd400, 16'sd4000);
        settle();

        // tick limit lowered below a partial count
        write_reg(CFG_TICKS_PER_SAMPLE, 8'd4);
        write_reg(CFG_SAMPLES_PER_AVERAGE, 8'd1);
        send_tick(16'sd11, 16'sd22, 16'sd33);
        send_tick(16'sd44, 16'sd55, 16'sd66);
        settle();
        write_reg(CFG_TICKS_PER_SAMPLE, 8'd1);
        send_tick(-16'sd3000, 16'sd1500, -16'sd800);
        settle();

        // long result hold-off while ticks keep coming: the block fills and stalls
        hold_req <= 1'b1;
        run_phase(1, 2, 40, 1'b0, 1'b0);

        // register extremes
        run_phase(255, 1, 1, 1'b1, 1'b0);
        run_phase(1, 255, 255, 1'b0, 1'b1);

        // random phases, mostly small windows
        while (taken < TICK_TARGET)
        begin
            r = $urandom_range(0, 9);
            tps = (r <= 5) ? 1 : (r <= 7) ? 2 : (r == 8) ? 3 : 0;
            r = $urandom_range(0, 9);
            case (r)
                0, 1:    spa = 1;
                2, 3:    spa = 2;
                4:       spa = 3;
                5:       spa = 4;
                6:       spa = 0;
                7, 8:    spa = $urandom_range(5, 12);
                default: spa = $urandom_range(13, 40);
            endcase
            nsamp = $urandom_range(4, 16);
            run_phase(tps, spa, nsamp, $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
            taken += nsamp * ((tps == 0) ? 1 : tps);
        end

        settle();
        if (failures == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
